[rtl/bfba_pkg.sv]
`default_nettype none
package bfba_pkg;

   localparam int DEF_MAX_BLOCKS = 64;
   localparam int DEF_ADDR_BITS  = 24;

   localparam int FIELD_W  = 24;
   localparam int HDR_W    = 7;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [FIELD_W-1:0] LIMIT_RESET  = 24'hFF_FFFF;
   localparam logic [HDR_W-1:0]   HEADER_RESET = 7'd24;

   localparam logic [CSR_IDX_W-1:0] REG_HEAP_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER     = 1'b1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd2;

   typedef struct packed {
      logic                reused;
      logic [FIELD_W-1:0]  granted_address;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage
`default_nettype wire

[rtl/bfba_table.sv]
`default_nettype none
module bfba_table #(
   parameter int DEPTH = bfba_pkg::DEF_MAX_BLOCKS,
   parameter int WIDTH = bfba_pkg::DEF_ADDR_BITS + bfba_pkg::FIELD_W + 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/bfba_engine.sv]
`default_nettype none
module bfba_engine #(
   parameter int MAX_BLOCKS = bfba_pkg::DEF_MAX_BLOCKS,
   parameter int ADDR_BITS  = bfba_pkg::DEF_ADDR_BITS,
   localparam int IDX_W = $clog2(MAX_BLOCKS),
   localparam int ENT_W = ADDR_BITS + bfba_pkg::FIELD_W + 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_op,
   input  wire logic [bfba_pkg::FIELD_W-1:0]    req_size,
   input  wire logic [bfba_pkg::FIELD_W-1:0]    req_addr,
   input  wire logic [bfba_pkg::FIELD_W-1:0]    cfg_limit,
   input  wire logic [bfba_pkg::HDR_W-1:0]      cfg_header,
   output logic                                 res_valid,
   input  wire logic                            res_ready,
   output bfba_pkg::result_type                 res,
   output logic                                 mem_wr_en,
   output logic      [IDX_W-1:0]                mem_wr_addr,
   output logic      [ENT_W-1:0]                mem_wr_data,
   output logic                                 mem_rd_en,
   output logic      [IDX_W-1:0]                mem_rd_addr,
   input  wire logic [ENT_W-1:0]                mem_rd_data
);

   localparam int FW    = bfba_pkg::FIELD_W;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CW    = ((ADDR_BITS > FW) ? ADDR_BITS : FW) + 2;
   localparam logic [CW-1:0] ADDR_MASK = CW'((64'd1 << ADDR_BITS) - 64'd1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic                 op_ff, op_in;
   logic [FW-1:0]        size_ff, size_in;
   logic [FW-1:0]        addr_ff, addr_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [FW-1:0]        best_len_ff, best_len_in;
   logic [ADDR_BITS-1:0] best_start_ff, best_start_in;
   logic                 best_free_ff, best_free_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ADDR_BITS-1:0] top_ff, top_in;

   logic                 ent_free;
   logic [FW-1:0]        ent_len;
   logic [ADDR_BITS-1:0] ent_start;
   logic [CW-1:0]        ent_data_addr;
   logic                 take;
   logic [CW-1:0]        need;
   logic [CW-1:0]        eff_limit;
   logic [CW-1:0]        top_data_addr;
   logic [CW-1:0]        best_data_addr;

   assign ent_free  = mem_rd_data[0];
   assign ent_len   = mem_rd_data[FW:1];
   assign ent_start = mem_rd_data[ENT_W-1:FW+1];

   assign ent_data_addr  = (CW'(ent_start) + CW'(cfg_header)) & ADDR_MASK;
   assign need           = CW'(top_ff) + CW'(cfg_header) + CW'(size_ff);
   assign eff_limit      = (CW'(cfg_limit) > ADDR_MASK) ? ADDR_MASK : CW'(cfg_limit);
   assign top_data_addr  = CW'(top_ff) + CW'(cfg_header);
   assign best_data_addr = CW'(best_start_ff) + CW'(cfg_header);

   assign req_ready   = (state_ff == S_IDLE);
   assign mem_rd_en   = (state_ff == S_SCAN) && (rd_idx_ff < count_ff);
   assign mem_rd_addr = rd_idx_ff[IDX_W-1:0];

   always_comb begin
      if (op_ff == bfba_pkg::OP_ALLOC) begin
         take = ent_free && (ent_len >= size_ff) && (!found_ff || (best_len_ff > ent_len));
      end else begin
         take = (ent_data_addr == CW'(addr_ff)) && !found_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      rd_idx_in     = rd_idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      best_free_in  = best_free_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      res_valid     = 1'b0;
      res           = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = best_idx_ff;
      mem_wr_data   = {best_start_ff, best_len_ff, 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               size_in   = req_size;
               addr_in   = req_addr;
               rd_idx_in = '0;
               found_in  = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (mem_rd_en) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[IDX_W-1:0];
            end
            if (chk_vld_ff && take) begin
               found_in      = 1'b1;
               best_idx_in   = chk_idx_ff;
               best_len_in   = ent_len;
               best_start_in = ent_start;
               best_free_in  = ent_free;
            end
            if (!mem_rd_en && !chk_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (op_ff == bfba_pkg::OP_ALLOC) begin
               if (found_ff) begin
                  mem_wr_en           = res_ready;
                  res.status          = bfba_pkg::ST_DONE;
                  res.granted_address = best_data_addr[FW-1:0];
                  res.reused          = 1'b1;
               end else if ((count_ff >= CNT_W'(MAX_BLOCKS)) || (need > eff_limit)) begin
                  res.status = bfba_pkg::ST_NO_SPACE;
               end else begin
                  mem_wr_en           = res_ready;
                  mem_wr_addr         = count_ff[IDX_W-1:0];
                  mem_wr_data         = {top_ff, size_ff, 1'b0};
                  res.status          = bfba_pkg::ST_DONE;
                  res.granted_address = top_data_addr[FW-1:0];
                  if (res_ready) begin
                     count_in = count_ff + 1'b1;
                     top_in   = need[ADDR_BITS-1:0];
                  end
               end
            end else begin
               if ((addr_ff != '0) && found_ff && !best_free_ff) begin
                  mem_wr_en   = res_ready;
                  mem_wr_data = {best_start_ff, best_len_ff, 1'b1};
                  res.status  = bfba_pkg::ST_DONE;
               end else begin
                  res.status = bfba_pkg::ST_IGNORED;
               end
            end
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
         count_ff   <= '0;
         top_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         count_ff   <= count_in;
         top_ff     <= top_in;
      end
      op_ff         <= op_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      best_free_ff  <= best_free_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("table count beyond depth");

   a_write_at_end: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_DONE) && res_ready)
      else $error("table written outside completion");

   a_check_follows_read: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> $past(mem_rd_en))
      else $error("entry checked without a read");

   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !mem_rd_en)
      else $error("read and write overlap");

   a_top_grows: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (top_ff >= $past(top_ff)))
      else $error("heap top moved back on append");

endmodule
`default_nettype wire

[rtl/best_fit_block_allocator_core.sv]
`default_nettype none
// Best-fit heap block allocator. Each request transaction (req_tuser 0 allocate,
// 1 free) walks the block table held in a single-port-read synchronous RAM, one
// entry per cycle. One result transaction per request; a finished result waits
// in an output register while the next request is taken. Registers: index 0
// heap limit, index 1 header bytes (0 acts as 1). Write them only while the
// block is idle.
module best_fit_block_allocator_core #(
   parameter int MAX_BLOCKS = bfba_pkg::DEF_MAX_BLOCKS,
   parameter int ADDR_BITS  = bfba_pkg::DEF_ADDR_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [47:0]                       req_tdata,   // request_size, data_address
   input  wire logic                              req_tuser,   // op
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [31:0]                       rsp_tdata,   // status, granted_address, reused
   input  wire logic                              csr_wr_en,
   input  wire logic [bfba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bfba_pkg::FIELD_W-1:0]      csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int ENT_W = ADDR_BITS + bfba_pkg::FIELD_W + 1;
   localparam int RES_W = $bits(bfba_pkg::result_type);

   logic [bfba_pkg::FIELD_W-1:0] limit_ff, limit_in;
   logic [bfba_pkg::HDR_W-1:0]   header_ff, header_in;
   logic [bfba_pkg::HDR_W-1:0]   eff_header;

   logic                 rsp_vld_ff, rsp_vld_in;
   bfba_pkg::result_type rsp_ff, rsp_in;

   logic                 res_valid, res_ready;
   bfba_pkg::result_type res;

   logic             mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [ENT_W-1:0] mem_wr_data, mem_rd_data;

   always_comb begin
      limit_in  = limit_ff;
      header_in = header_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bfba_pkg::REG_HEAP_LIMIT: limit_in  = csr_wr_data;
            bfba_pkg::REG_HEADER:     header_in = csr_wr_data[bfba_pkg::HDR_W-1:0];
            default: ;
         endcase
      end
   end

   assign eff_header = (header_ff == '0) ? bfba_pkg::HDR_W'(1) : header_ff;

   assign res_ready  = !rsp_vld_ff || rsp_tready;
   assign rsp_vld_in = res_valid || (rsp_vld_ff && !rsp_tready);
   assign rsp_in     = (res_valid && res_ready) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= bfba_pkg::LIMIT_RESET;
         header_ff  <= bfba_pkg::HEADER_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         limit_ff   <= limit_in;
         header_ff  <= header_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(32 - RES_W)'(0), rsp_ff};

   bfba_table #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (ENT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bfba_engine #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_size    (req_tdata[23:0]),
      .req_addr    (req_tdata[47:24]),
      .cfg_limit   (limit_ff),
      .cfg_header  (eff_header),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule
`default_nettype wire
